// File: hw/rtl/ibp_pkg.sv
package ibp_pkg;

  localparam int MAX_BLOCK = 64;
  localparam int IDX_W     = 6;
  localparam int SIZE_W    = 7;
  localparam int PIX_W     = 8;
  localparam int DIVR_W    = SIZE_W + 1;          // width + height, up to 2 * MAX_BLOCK
  localparam int DIV_STEPS = PIX_W;               // one quotient bit per step
  localparam int SUM_W     = DIVR_W + DIV_STEPS;  // rounded sum keeps quotient below 256
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [PIX_W-1:0]  PIX_RESET = PIX_W'(127);
  localparam logic [PIX_W-1:0]  PIX_MAX   = PIX_W'(255);
  localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(MAX_BLOCK);
  localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(1);

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ABOVE = 2'd1,
    KIND_LEFT  = 2'd2,
    KIND_ROW   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_DC = 2'd0,
    MODE_V  = 2'd1,
    MODE_H  = 2'd2,
    MODE_TM = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    mode_t              mode;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [PIX_W-1:0]   corner;
    logic [IDX_W-1:0]   index;
    logic [PIX_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] column;
    logic             last;
  } out_item_t;

  // command passed from front end to back end; sizes already clamped
  typedef struct packed {
    kind_t              kind;
    mode_t              mode;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [PIX_W-1:0]   corner;
    logic [IDX_W-1:0]   index;
    logic [PIX_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_MIN;
    else if (v > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

endpackage

// File: hw/rtl/ibp_front.sv
module ibp_front import ibp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output cmd_t     q_cmd
);

  // front keeps its own copy of the block height to drop rows past the block
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic              accept;
  logic              keep;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_cmd        = '0;
    q_cmd.kind   = in_data.kind;
    q_cmd.mode   = in_data.mode;
    q_cmd.width  = clamp_size(in_data.width);
    q_cmd.height = clamp_size(in_data.height);
    q_cmd.corner = in_data.corner;
    q_cmd.index  = in_data.index;
    q_cmd.value  = in_data.value;
    height_nxt   = height_r;
    keep         = 1'b0;
    unique case (in_data.kind)
      KIND_START: begin
        keep = 1'b1;
        if (accept) height_nxt = q_cmd.height;
      end
      KIND_ABOVE, KIND_LEFT: keep = (SIZE_W'(in_data.index) < SIZE_MAX);
      KIND_ROW:   keep = (SIZE_W'(in_data.index) < height_r);
      default:    keep = 1'b0;
    endcase
  end

  assign q_push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= SIZE_MIN;
    end else begin
      height_r <= height_nxt;
    end
  end

endmodule

// File: hw/rtl/ibp_queue.sv
module ibp_queue import ibp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t stat
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign head_cmd   = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop)      count_r <= count_r + (Q_PTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (Q_PTR_W+1)'(1);
    end
  end

endmodule

// File: hw/rtl/ibp_div.sv
module ibp_div import ibp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // restoring divider, one quotient bit per cycle. The quotient is known to
  // fit in DIV_STEPS bits, so the upper dividend bits start as the remainder.
  logic                    busy_r, done_r;
  logic [STEP_W-1:0]       step_r;
  logic [DIVR_W-1:0]       rem_r;
  logic [DIVR_W-1:0]       dvs_r;
  logic [DIV_STEPS-1:0]    num_r;
  logic [DIV_STEPS-1:0]    quot_r;
  logic [DIVR_W:0]         trial;
  logic                    fits;

  assign trial = {rem_r, num_r[DIV_STEPS-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[SUM_W-1:DIV_STEPS];
      num_r <= req.dividend[DIV_STEPS-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r  <= fits ? DIVR_W'(trial - {1'b0, dvs_r}) : trial[DIVR_W-1:0];
      num_r  <= {num_r[DIV_STEPS-2:0], 1'b0};
      quot_r <= {quot_r[DIV_STEPS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ibp_back.sv
module ibp_back import ibp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head_cmd,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // block parameters
  mode_t             mode_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [PIX_W-1:0]  corner_r;

  // neighbor stores; an entry reads as PIX_RESET until written
  logic [PIX_W-1:0]     above_mem [MAX_BLOCK];
  logic [PIX_W-1:0]     left_mem  [MAX_BLOCK];
  logic [MAX_BLOCK-1:0] above_vb_r, left_vb_r;
  logic [PIX_W-1:0]     above_q_r, left_q_r;
  logic                 above_vq_r, left_vq_r;
  logic [PIX_W-1:0]     above_v, left_v;

  // row sequencing
  logic [IDX_W-1:0]  row_r, col_r;
  logic              iss_done_r;
  logic              p1_vld_r, p1_last_r;
  logic [IDX_W-1:0]  p1_col_r;
  logic              col_last;

  // DC sum
  logic [SIZE_W-1:0] k_r, lim;
  logic [SUM_W-1:0]  acc_r;
  logic              acc_p_r, acc_a_r, acc_l_r;
  logic [PIX_W-1:0]  dc_r;
  logic [DIVR_W-1:0] n_sum;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              out_vld_r;
  out_item_t         out_data_r;

  logic              advance, issue, sum_iss, rd_en, wr_a, wr_l;
  logic [IDX_W-1:0]  rd_a_addr, rd_l_addr;
  logic signed [PIX_W+1:0] tm_raw;
  logic [PIX_W-1:0]  pix;

  assign advance  = !out_vld_r || out_ready;
  assign q_pop    = (state_r == ST_IDLE) && !q_stat.empty;
  assign wr_a     = q_pop && (head_cmd.kind == KIND_ABOVE);
  assign wr_l     = q_pop && (head_cmd.kind == KIND_LEFT);
  assign issue    = (state_r == ST_EMIT) && !iss_done_r && advance;
  assign lim      = (width_r > height_r) ? width_r : height_r;
  assign sum_iss  = (state_r == ST_SUM) && (k_r < lim);
  assign rd_en    = issue || sum_iss;
  assign rd_a_addr = (state_r == ST_SUM) ? k_r[IDX_W-1:0] : col_r;
  assign rd_l_addr = (state_r == ST_SUM) ? k_r[IDX_W-1:0] : row_r;
  assign col_last = ((SIZE_W'(col_r) + SIZE_W'(1)) == width_r);

  assign above_v = above_vq_r ? above_q_r : PIX_RESET;
  assign left_v  = left_vq_r  ? left_q_r  : PIX_RESET;

  assign n_sum            = DIVR_W'(width_r) + DIVR_W'(height_r);
  assign div_req.start    = (state_r == ST_SUM) && !sum_iss && !acc_p_r;
  assign div_req.dividend = acc_r + SUM_W'(n_sum >> 1);
  assign div_req.divisor  = n_sum;

  ibp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // store write and registered read
  always_ff @(posedge clk) begin
    if (wr_a) above_mem[head_cmd.index] <= head_cmd.value;
    if (wr_l) left_mem[head_cmd.index]  <= head_cmd.value;
    if (rd_en) begin
      above_q_r  <= above_mem[rd_a_addr];
      left_q_r   <= left_mem[rd_l_addr];
      above_vq_r <= above_vb_r[rd_a_addr];
      left_vq_r  <= left_vb_r[rd_l_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_vb_r <= '0;
      left_vb_r  <= '0;
    end else begin
      if (wr_a) above_vb_r[head_cmd.index] <= 1'b1;
      if (wr_l) left_vb_r[head_cmd.index]  <= 1'b1;
    end
  end

  always_comb begin
    tm_raw = $signed({2'b00, above_v}) + $signed({2'b00, left_v})
           - $signed({2'b00, corner_r});
    unique case (mode_r)
      MODE_DC: pix = dc_r;
      MODE_V:  pix = above_v;
      MODE_H:  pix = left_v;
      MODE_TM: begin
        if (tm_raw < 0)                           pix = '0;
        else if (tm_raw > $signed({2'b00, PIX_MAX})) pix = PIX_MAX;
        else                                      pix = tm_raw[PIX_W-1:0];
      end
      default: pix = dc_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && head_cmd.kind == KIND_ROW) begin
          state_nxt = (mode_r == MODE_DC) ? ST_SUM : ST_EMIT;
        end
      end
      ST_SUM:  if (div_req.start) state_nxt = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_EMIT;
      ST_EMIT: if (iss_done_r && !p1_vld_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_DC;
      width_r   <= SIZE_MIN;
      height_r  <= SIZE_MIN;
      corner_r  <= PIX_RESET;
      p1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      acc_p_r   <= 1'b0;
      iss_done_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (q_pop && head_cmd.kind == KIND_START) begin
        mode_r   <= head_cmd.mode;
        width_r  <= head_cmd.width;
        height_r <= head_cmd.height;
        corner_r <= head_cmd.corner;
      end
      if (q_pop && head_cmd.kind == KIND_ROW) begin
        iss_done_r <= 1'b0;
        acc_p_r    <= 1'b0;
      end else begin
        if (issue && col_last) iss_done_r <= 1'b1;
        if (state_r == ST_SUM) acc_p_r <= sum_iss;
      end
      if (advance) begin
        p1_vld_r  <= issue;
        out_vld_r <= p1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head_cmd.kind == KIND_ROW) begin
      row_r <= head_cmd.index;
      col_r <= '0;
      k_r   <= '0;
      acc_r <= '0;
    end else begin
      if (issue) col_r <= col_r + IDX_W'(1);
      if (sum_iss) k_r <= k_r + SIZE_W'(1);
      if (state_r == ST_SUM && acc_p_r) begin
        acc_r <= acc_r + SUM_W'(acc_a_r ? above_v : '0) + SUM_W'(acc_l_r ? left_v : '0);
      end
    end
    if (sum_iss) begin
      acc_a_r <= (k_r < width_r);
      acc_l_r <= (k_r < height_r);
    end
    if (div_rsp.done) dc_r <= div_rsp.quot;
    if (issue) begin
      p1_col_r  <= col_r;
      p1_last_r <= col_last;
    end
    if (advance && p1_vld_r) begin
      out_data_r.pixel  <= pix;
      out_data_r.column <= p1_col_r;
      out_data_r.last   <= p1_last_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/intra_block_predictor.sv
// Block starts and neighbor loads: one request per cycle while the queue is not full.
// Row request, V/H/TM: after the queue pop, a registered store read feeds the output
//   register, then width pixels follow at one pixel per cycle while out_ready is high.
// Row request, DC: first sums the stores over max(width, height) entries, then divides.
// Reset: synchronous, active low; stores read as 127 until written, mode DC, size 1x1.
module intra_block_predictor import ibp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  cmd_t    q_cmd, head_cmd;

  ibp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  ibp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  ibp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sim/intra_block_predictor_tb.sv
`timescale 1ns / 100ps

module intra_block_predictor_tb;
  import ibp_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  intra_block_predictor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predictor state, mirrors the block after every accepted request
  logic [PIX_W-1:0] above_px [MAX_BLOCK];
  logic [PIX_W-1:0] left_px  [MAX_BLOCK];
  mode_t            cur_mode;
  int               cur_width;
  int               cur_height;
  int               cur_corner;

  out_item_t expected_pixels [$];

  int send_gap_max    = 17;
  int ready_stall_max = 17;
  bit results_held    = 1'b0;

  int error_count    = 0;
  int pixels_checked = 0;
  int requests_sent  = 0;
  int starts_sent    = 0;
  int loads_sent     = 0;
  int rows_sent      = 0;
  int rows_by_mode [4];

  function automatic void predict_request(in_item_t req);
    int sum;
    int n;
    int dc;
    int v;
    out_item_t px;
    case (req.kind)
      KIND_START: begin
        cur_mode   = req.mode;
        cur_width  = (req.width == 0) ? 1 : (req.width > MAX_BLOCK) ? MAX_BLOCK : req.width;
        cur_height = (req.height == 0) ? 1 : (req.height > MAX_BLOCK) ? MAX_BLOCK : req.height;
        cur_corner = req.corner;
      end
      KIND_ABOVE: begin
        if (req.index < MAX_BLOCK) above_px[req.index] = req.value;
      end
      KIND_LEFT: begin
        if (req.index < MAX_BLOCK) left_px[req.index] = req.value;
      end
      default: begin
        if (req.index < cur_height) begin
          rows_by_mode[cur_mode]++;
          sum = 0;
          n   = cur_width + cur_height;
          for (int i = 0; i < cur_width; i++) sum += above_px[i];
          for (int i = 0; i < cur_height; i++) sum += left_px[i];
          dc = (sum + n / 2) / n;
          for (int col = 0; col < cur_width; col++) begin
            case (cur_mode)
              MODE_DC: v = dc;
              MODE_V:  v = above_px[col];
              MODE_H:  v = left_px[req.index];
              default: begin
                v = above_px[col] + left_px[req.index] - cur_corner;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
              end
            endcase
            px.pixel  = PIX_W'(v);
            px.column = IDX_W'(col);
            px.last   = (col == cur_width - 1);
            expected_pixels.push_back(px);
          end
        end
      end
    endcase
  endfunction

  function automatic in_item_t junk_request();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // valid goes up at a falling edge and stays up until the request is taken
  task automatic send_request(in_item_t req);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req);
    requests_sent++;
    case (req.kind)
      KIND_START: starts_sent++;
      KIND_ROW:   rows_sent++;
      default:    loads_sent++;
    endcase
  endtask

  task automatic send_start(mode_t m, int w, int h, int c);
    in_item_t req;
    req        = junk_request();
    req.kind   = KIND_START;
    req.mode   = m;
    req.width  = SIZE_W'(w);
    req.height = SIZE_W'(h);
    req.corner = PIX_W'(c);
    send_request(req);
  endtask

  task automatic send_load(kind_t k, int idx, int val);
    in_item_t req;
    req       = junk_request();
    req.kind  = k;
    req.index = IDX_W'(idx);
    req.value = PIX_W'(val);
    send_request(req);
  endtask

  task automatic send_row(int idx);
    in_item_t req;
    req       = junk_request();
    req.kind  = KIND_ROW;
    req.index = IDX_W'(idx);
    send_request(req);
  endtask

  task automatic hold_results(int cycles);
    fork
      begin
        results_held = 1'b1;
        repeat (cycles) @(posedge clk);
        results_held = 1'b0;
      end
    join_none
  endtask

  // receiver: a fresh stall per pixel, plus any hold-off in progress
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = $urandom_range(0, ready_stall_max);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      while (results_held || !rst_n) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic note_mismatch(string what);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel %0d column %0d last %0b",
                                out_data.pixel, out_data.column, out_data.last));
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel !== want.pixel || out_data.column !== want.column ||
            out_data.last !== want.last)
          note_mismatch($sformatf("pixel %0d/%0d column %0d/%0d last %0b/%0b (exp/got)",
                                  want.pixel, out_data.pixel, want.column,
                                  out_data.column, want.last, out_data.last));
      end
    end
  end

  // stores come up at 127, mode DC, 1x1
  task automatic test_reset_state();
    send_row(0);
    send_row(1);
  endtask

  task automatic test_true_motion_clamp();
    send_start(MODE_TM, 4, 2, 200);
    send_load(KIND_ABOVE, 0, 255);
    send_load(KIND_ABOVE, 1, 0);
    send_load(KIND_ABOVE, 3, 170);
    send_load(KIND_LEFT, 0, 255);
    send_load(KIND_LEFT, 1, 0);
    send_row(0);
    send_row(1);
    send_row(2);
  endtask

  // out-of-range sizes; no idling on either side here
  task automatic test_size_clamp_dc();
    send_gap_max    = 0;
    ready_stall_max = 0;
    send_start(MODE_DC, 127, 0, 0);
    send_row(0);
    send_start(MODE_DC, 0, 65, 0);
    send_row(63);
    send_gap_max    = 17;
    ready_stall_max = 17;
  endtask

  task automatic test_vertical_horizontal_extremes();
    send_start(MODE_V, 64, 64, 255);
    send_load(KIND_ABOVE, 63, 85);
    send_row(63);
    send_start(MODE_H, 3, 64, 0);
    send_load(KIND_LEFT, 63, 170);
    send_row(63);
    send_start(MODE_TM, 127, 127, 255);
    send_row(63);
  endtask

  // receiver holds off while rows pile up behind the full command queue
  task automatic test_backpressure();
    send_gap_max = 0;
    send_start(MODE_V, 64, 8, 0);
    hold_results(400);
    for (int r = 0; r < 8; r++) send_row(r);
    send_gap_max = 17;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 4) return $urandom_range(65, 127);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 32);
    return $urandom_range(33, 64);
  endfunction

  task automatic test_random_blocks(int budget);
    int stop_at;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        send_gap_max    = 0;
        ready_stall_max = 0;
      end else begin
        send_gap_max    = 17;
        ready_stall_max = 17;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_request(junk_request());
      end else begin
        send_start(mode_t'($urandom_range(0, 3)), pick_size(), pick_size(),
                   $urandom_range(0, 255));
        for (int i = 0; i < cur_width; i++)
          if ($urandom_range(0, 3) != 0) send_load(KIND_ABOVE, i, $urandom_range(0, 255));
        for (int i = 0; i < cur_height; i++)
          if ($urandom_range(0, 3) != 0) send_load(KIND_LEFT, i, $urandom_range(0, 255));
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 6) == 0) send_row($urandom_range(0, 63));
          else send_row($urandom_range(0, cur_height - 1));
        end
      end
    end
    send_gap_max    = 17;
    ready_stall_max = 17;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (above_px[i]) begin
      above_px[i] = PIX_RESET;
      left_px[i]  = PIX_RESET;
    end
    cur_mode   = MODE_DC;
    cur_width  = 1;
    cur_height = 1;
    cur_corner = 127;
    foreach (rows_by_mode[i]) rows_by_mode[i] = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_true_motion_clamp();
    test_size_clamp_dc();
    test_vertical_horizontal_extremes();
    test_backpressure();
    test_random_blocks(240);

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d requests: %0d block starts, %0d neighbor loads, %0d row requests",
             requests_sent, starts_sent, loads_sent, rows_sent);
    $display("Checked %0d pixels; rows by mode DC %0d, V %0d, H %0d, TM %0d",
             pixels_checked, rows_by_mode[MODE_DC], rows_by_mode[MODE_V],
             rows_by_mode[MODE_H], rows_by_mode[MODE_TM]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout, %0d pixels still expected", expected_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ibp_pkg.sv
hw/rtl/ibp_front.sv
hw/rtl/ibp_queue.sv
hw/rtl/ibp_div.sv
hw/rtl/ibp_back.sv
hw/rtl/intra_block_predictor.sv
sim/intra_block_predictor_tb.sv
